// ===== design/psi_pkg.sv =====
// Shared constants, types and functions of the polyphase sinc interpolator.
package psi_pkg;

    // Sizes of the filter and its table.
    localparam int MAX_FACTOR  = 64;
    localparam int TAPS        = 5;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_FRAC   = 14;
    localparam int LINE_DEPTH  = TAPS + 1;
    localparam int TABLE_DEPTH = TAPS * MAX_FACTOR;

    // Widths, some derived from the sizes above.
    localparam int ADDR_W   = 9;
    localparam int PHASE_W  = $clog2(MAX_FACTOR);
    localparam int LEN_W    = $clog2(MAX_FACTOR + 1);
    localparam int FACTOR_W = 7;
    localparam int FILL_W   = 3;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(TAPS);
    localparam int Q_W      = ACC_W + 1 - COEF_FRAC;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(10);

    // Item codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // Rounding and saturation constants.
    localparam logic signed [ACC_W:0]   RND_HALF = (ACC_W + 1)'(1) << (COEF_FRAC - 1);
    localparam logic signed [Q_W-1:0]   SAT_MAX  = Q_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_MIN  = ~SAT_MAX;

    // One output phase travelling down the chain of tap cells.
    typedef struct packed {
        logic                    valid;
        logic [ADDR_W-1:0]       k;
        logic                    sel;
        logic [PHASE_W-1:0]      phase;
        logic                    last;
        logic signed [ACC_W-1:0] acc;
    } t_tok;

    // Round half up to Q1.15 and saturate to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] s;
        logic signed [Q_W-1:0] q;
        s = {acc[ACC_W-1], acc} + RND_HALF;
        q = s[ACC_W:COEF_FRAC];
        if (q > SAT_MAX) begin
            return SAT_MAX[SAMPLE_W-1:0];
        end else if (q < SAT_MIN) begin
            return SAT_MIN[SAMPLE_W-1:0];
        end
        return q[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== design/psi_tap_cell.sv =====
// One tap cell: two delay-line taps, a coefficient bank, a multiplier and an adder.
module psi_tap_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_wr,
    input  logic [psi_pkg::ADDR_W-1:0]    i_wr_addr,
    input  logic signed [psi_pkg::COEF_W-1:0]   i_wr_data,
    input  logic                          i_shift,
    input  logic signed [psi_pkg::SAMPLE_W-1:0] i_shift_in,
    input  logic [psi_pkg::LEN_W-1:0]     i_len,
    input  psi_pkg::t_tok                 i_tok,
    output psi_pkg::t_tok                 o_tok,
    output logic signed [psi_pkg::SAMPLE_W-1:0] o_tap_hi,
    output logic                          o_busy
);
    import psi_pkg::*;

    logic signed [COEF_W-1:0]   r_mem [0:TABLE_DEPTH-1];
    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SAMPLE_W-1:0] r_hi;
    logic signed [COEF_W-1:0]   r_coef;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_a_valid;
    logic                       r_b_valid;
    logic                       r_c_valid;
    t_tok                       r_a_tok;
    t_tok                       r_b_tok;
    t_tok                       r_c_tok;
    t_tok                       n_c_tok;

    // Coefficient bank: every cell keeps a full copy of the table.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_en) begin
            r_coef <= r_mem[i_tok.k];
        end
    end

    // Taps of this cell; the upper tap takes the neighbour's upper tap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_shift) begin
            r_lo <= r_hi;
            r_hi <= i_shift_in;
        end
    end

    // Valid flags of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_tok.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Stage C adds this cell's product and steps the table address on by one period.
    always_comb begin
        n_c_tok     = r_b_tok;
        n_c_tok.k   = r_b_tok.k + ADDR_W'(i_len);
        n_c_tok.acc = r_b_tok.acc + ACC_W'(r_prod);
    end

    // Stage A reads the coefficient and picks the tap, B multiplies, C accumulates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tok <= i_tok;
            r_x     <= i_tok.sel ? r_hi : r_lo;
            r_b_tok <= r_a_tok;
            r_prod  <= r_coef * r_x;
            r_c_tok <= n_c_tok;
        end
    end

    always_comb begin
        o_tok       = r_c_tok;
        o_tok.valid = r_c_valid;
    end

    assign o_tap_hi = r_hi;
    assign o_busy   = r_a_valid | r_b_valid | r_c_valid;

endmodule

// ===== design/psi_sequencer.sv =====
// Fill counter and phase sequencer that feeds output phases into the cell chain.
module psi_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_smp_beat,
    input  logic                      i_record_start,
    input  logic [psi_pkg::LEN_W-1:0] i_len,
    output psi_pkg::t_tok             o_tok,
    output logic                      o_active
);
    import psi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq_state;

    t_seq_state           r_state;
    t_seq_state           n_state;
    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill;
    logic [FILL_W-1:0]    w_fill_base;
    logic [PHASE_W-1:0]   r_j;
    logic [PHASE_W-1:0]   n_j;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     n_len;
    logic                 w_last;

    // Fill count: cleared by a record start before the new sample is counted.
    always_comb begin
        w_fill_base = i_record_start ? '0 : r_fill;
        n_fill      = r_fill;
        if (i_smp_beat) begin
            n_fill = (w_fill_base < FILL_W'(LINE_DEPTH)) ? w_fill_base + FILL_W'(1)
                                                         : w_fill_base;
        end
    end

    assign w_last = ({1'b0, r_j} == (r_len - LEN_W'(1)));

    // Run control: one phase per advancing cycle until the last phase.
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_len   = r_len;
        case (r_state)
            S_IDLE: begin
                if (i_smp_beat && (n_fill == FILL_W'(LINE_DEPTH)) && (i_len != '0)) begin
                    n_state = S_RUN;
                    n_j     = '0;
                    n_len   = i_len;
                end
            end
            S_RUN: begin
                if (i_en) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j = r_j + PHASE_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j   <= n_j;
        r_len <= n_len;
    end

    // Phase token: phase 0 starts at table word 0, phase j at word L-j.
    always_comb begin
        o_tok.valid = (r_state == S_RUN);
        o_tok.k     = (r_j == '0) ? '0 : ADDR_W'(r_len - LEN_W'(r_j));
        o_tok.sel   = (r_j != '0);
        o_tok.phase = r_j;
        o_tok.last  = w_last;
        o_tok.acc   = '0;
    end

    assign o_active = (r_state == S_RUN);

endmodule

// ===== design/polyphase_sinc_interpolator_core.sv =====
// Top level of the polyphase sinc interpolator: sequencer, chain of tap cells, output register.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready    i_opcode, i_sample_in, i_record_start,
//                                                 i_coef_index, i_coef_value
//  out      output     o_out_valid / i_out_ready  o_sample_out, o_phase, o_last_of_run
//  cfg      input      i_cfg_we                   i_cfg_wdata (factor)
//
// A coefficient write, or a sample that yields no output, leaves the input ready again.
// A sample that yields outputs holds the input off while its L phases are issued and
// pass the three register stages in each of the five tap cells; a stall at the output
// lengthens this, and no new beat is taken before the last phase leaves the chain.
// Reset is synchronous and active low; the coefficient table is not cleared.
// While a result waits at the output, the tap-cell stages and the phase sequencer hold.
module polyphase_sinc_interpolator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic signed [psi_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                i_record_start,
    input  logic [psi_pkg::ADDR_W-1:0]          i_coef_index,
    input  logic signed [psi_pkg::COEF_W-1:0]   i_coef_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [psi_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic [psi_pkg::PHASE_W-1:0]         o_phase,
    output logic                                o_last_of_run,
    input  logic                                i_cfg_we,
    input  logic [psi_pkg::FACTOR_W-1:0]        i_cfg_wdata
);
    import psi_pkg::*;

    logic [FACTOR_W-1:0]        r_factor;
    logic [LEN_W-1:0]           w_len;
    logic                       w_en;
    logic                       w_beat;
    logic                       w_smp_beat;
    logic                       w_cwr;
    logic                       w_active;
    logic                       w_busy_any;
    logic [TAPS-1:0]            w_busy;
    t_tok                       w_tok [0:TAPS];
    logic signed [SAMPLE_W-1:0] w_hi  [0:TAPS];
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic [PHASE_W-1:0]         r_phase;
    logic                       r_last;

    // Factor register; values above the table size act as the largest factor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
        end else if (i_cfg_we) begin
            r_factor <= i_cfg_wdata;
        end
    end

    assign w_len = (r_factor > FACTOR_W'(MAX_FACTOR)) ? LEN_W'(MAX_FACTOR) : LEN_W'(r_factor);

    // Input beats are taken only while no phase is in flight.
    assign w_busy_any = |w_busy;
    assign o_in_ready = !w_active && !w_busy_any;
    assign w_beat     = i_in_valid && o_in_ready;
    assign w_smp_beat = w_beat && (i_opcode == OP_SAMPLE);
    assign w_cwr      = w_beat && (i_opcode == OP_COEF) &&
                        (i_coef_index < ADDR_W'(TABLE_DEPTH));

    // The chain advances unless a result waits at the output.
    assign w_en = !r_out_valid || i_out_ready;

    psi_sequencer u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_smp_beat     (w_smp_beat),
        .i_record_start (i_record_start),
        .i_len          (w_len),
        .o_tok          (w_tok[0]),
        .o_active       (w_active)
    );

    // Chain of tap cells; the newest sample enters at the far end.
    assign w_hi[TAPS] = i_sample_in;

    for (genvar m = 0; m < TAPS; m++) begin : g_cell
        psi_tap_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_wr       (w_cwr),
            .i_wr_addr  (i_coef_index),
            .i_wr_data  (i_coef_value),
            .i_shift    (w_smp_beat),
            .i_shift_in (w_hi[m+1]),
            .i_len      (w_len),
            .i_tok      (w_tok[m]),
            .o_tok      (w_tok[m+1]),
            .o_tap_hi   (w_hi[m]),
            .o_busy     (w_busy[m])
        );
    end

    // Output register with rounding and saturation in front of it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tok[TAPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_tok[TAPS].valid) begin
            r_sample_out <= round_sat(w_tok[TAPS].acc);
            r_phase      <= w_tok[TAPS].phase;
            r_last       <= w_tok[TAPS].last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_sample_out;
    assign o_phase       = r_phase;
    assign o_last_of_run = r_last;

`ifndef NO_ASSERTIONS
    // The table is never written while a phase may still read it.
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cwr |-> !w_busy_any && !w_active)
        else $error("coefficient write while the chain is busy");

    // A run always opens with phase zero.
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_active) |-> w_tok[0].valid && (w_tok[0].phase == '0))
        else $error("run did not start at phase zero");

    // The last-of-run flag marks exactly phase L-1.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_of_run == ({1'b0, o_phase} == (w_len - LEN_W'(1)))))
        else $error("last-of-run flag does not match phase");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the polyphase sinc interpolator core.
`timescale 1ns / 1ps

module tb;
    import psi_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 100;
    localparam int HOLD_CYCLES = 400;

    // One input beat: a sample or a coefficient write.
    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       rs;
        logic [ADDR_W-1:0]          idx;
        logic signed [COEF_W-1:0]   cval;
    } t_item;

    // One output beat.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] val;
        logic [PHASE_W-1:0]         ph;
        logic                       last;
    } t_out;

    // One row of the directed table; a typed row carries its phase-0 result at factor 1.
    typedef struct packed {
        t_item                      it;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] want;
    } t_drow;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_ready;
    logic                       i_opcode       = OP_SAMPLE;
    logic signed [SAMPLE_W-1:0] i_sample_in    = '0;
    logic                       i_record_start = 1'b0;
    logic [ADDR_W-1:0]          i_coef_index   = '0;
    logic signed [COEF_W-1:0]   i_coef_value   = '0;
    logic                       o_out_valid;
    logic                       i_out_ready    = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic [PHASE_W-1:0]         o_phase;
    logic                       o_last_of_run;
    logic                       i_cfg_we       = 1'b0;
    logic [FACTOR_W-1:0]        i_cfg_wdata    = '0;

    // Predictor state.
    logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
    logic signed [COEF_W-1:0]   coef_mem [TABLE_DEPTH];
    int                         fill_cnt = 0;
    int                         factor_q = FACTOR_RESET;

    t_out pending_outs [$];
    t_drow drows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_ask      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int n_checked     = 0;
    int n_directed    = 0;
    int n_random      = 0;
    int n_settings    = 0;
    int cycle_count   = 0;

    polyphase_sinc_interpolator_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_sample_in    (i_sample_in),
        .i_record_start (i_record_start),
        .i_coef_index   (i_coef_index),
        .i_coef_value   (i_coef_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out),
        .o_phase        (o_phase),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Advance the interpolator by one accepted beat and queue the output beats it yields.
    task automatic interp_step(input t_item it, input bit push);
        int lim;
        int base;
        int sh;
        int j;
        int m;
        longint acc;
        longint q;
        if (it.op == OP_COEF) begin
            if (it.idx < TABLE_DEPTH) begin
                coef_mem[it.idx] = it.cval;
            end
            return;
        end
        if (it.rs) begin
            fill_cnt = 0;
        end
        for (m = 0; m < LINE_DEPTH - 1; m++) begin
            line_mem[m] = line_mem[m + 1];
        end
        line_mem[LINE_DEPTH - 1] = it.smp;
        if (fill_cnt < LINE_DEPTH) begin
            fill_cnt++;
        end
        if (fill_cnt < LINE_DEPTH) begin
            return;
        end
        lim = (factor_q > MAX_FACTOR) ? MAX_FACTOR : factor_q;
        for (j = 0; j < lim; j++) begin
            acc  = 0;
            base = (j == 0) ? 0 : lim - j;
            sh   = (j == 0) ? 0 : 1;
            for (m = 0; m < TAPS; m++) begin
                acc += longint'(coef_mem[base + m * lim]) * longint'(line_mem[m + sh]);
            end
            // Round half up, then clamp to the sample range.
            q = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
            if (q > 32767) begin
                q = 32767;
            end else if (q < -32768) begin
                q = -32768;
            end
            if (push) begin
                pending_outs.push_back(t_out'{q[SAMPLE_W-1:0], j[PHASE_W-1:0], j == lim - 1});
            end
        end
    endtask

    // Offer one beat after a random gap and wait for it to be taken.
    task automatic send_beat(input t_item it, input bit typed,
                             input logic signed [SAMPLE_W-1:0] want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= it.op;
        i_sample_in    <= it.smp;
        i_record_start <= it.rs;
        i_coef_index   <= it.idx;
        i_coef_value   <= it.cval;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        interp_step(it, !typed);
        if (typed) begin
            pending_outs.push_back(t_out'{want, PHASE_W'(0), 1'b1});
        end
    endtask

    // Wait until every expected beat has arrived and the pipeline has emptied.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_outs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_factor(input int fac);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= FACTOR_W'(fac);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        factor_q = fac;
        n_settings++;
    endtask

    // Mostly modest coefficients, so that sums do not always clip.
    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic signed [COEF_W-1:0] v;
        if ($urandom_range(0, 3) == 0) begin
            v = COEF_W'($urandom);
        end else begin
            v = COEF_W'($urandom_range(0, 8191)) - 16'sd4096;
        end
        return v;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.smp  = SAMPLE_W'($urandom);
        it.rs   = $urandom_range(0, 15) == 0;
        it.idx  = ADDR_W'($urandom);
        it.cval = COEF_W'($urandom);
        if ($urandom_range(0, 99) < 10) begin
            it.op   = OP_COEF;
            it.idx  = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(TABLE_DEPTH, 511))
                                                   : ADDR_W'($urandom_range(0, TABLE_DEPTH - 1));
            it.cval = rand_coef();
        end else begin
            it.op = OP_SAMPLE;
            case ($urandom_range(0, 15))
                0: begin
                    it.smp = 16'sh7FFF;
                end
                1: begin
                    it.smp = 16'sh8000;
                end
                default: begin
                end
            endcase
        end
        return it;
    endfunction

    // Write every table word, either with zeros or with random coefficients.
    task automatic load_table(input bit zeros);
        t_item it;
        int k;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            it.op   = OP_COEF;
            it.smp  = SAMPLE_W'($urandom);
            it.rs   = $urandom_range(0, 1);
            it.idx  = ADDR_W'(k);
            it.cval = zeros ? '0 : rand_coef();
            send_beat(it, 1'b0, '0);
        end
    endtask

    // One random phase at a given factor and idling pattern.
    task automatic run_phase(input int fac, input int s_pct, input int r_pct,
                             input int n_smp, input bit squeeze);
        t_item it;
        int got;
        set_factor(fac);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (squeeze) begin
            hold_ask++;
        end
        got = 0;
        while (got < n_smp) begin
            it = rand_item();
            send_beat(it, 1'b0, '0);
            if (it.op == OP_SAMPLE) begin
                got++;
            end
            n_random++;
        end
    endtask

    function automatic t_drow drow(input logic op, input logic signed [SAMPLE_W-1:0] s,
                                   input logic rs, input logic [ADDR_W-1:0] k,
                                   input logic signed [COEF_W-1:0] c, input logic typed,
                                   input logic signed [SAMPLE_W-1:0] want);
        return t_drow'{t_item'{op, s, rs, k, c}, typed, want};
    endfunction

    // Output side: random back-pressure, one long hold-off on request, and the checks.
    always @(posedge i_clk) begin : out_side
        t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outs.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat, sample_out %0d phase %0d last %0b",
                         $time, o_sample_out, o_phase, o_last_of_run);
            end else begin
                e = pending_outs.pop_front();
                n_checked++;
                if (o_sample_out !== e.val) begin
                    errors++;
                    $display("%0t: sample_out expected %0d, got %0d",
                             $time, e.val, o_sample_out);
                end
                if (o_phase !== e.ph) begin
                    errors++;
                    $display("%0t: phase expected %0d, got %0d", $time, e.ph, o_phase);
                end
                if (o_last_of_run !== e.last) begin
                    errors++;
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $time, e.last, o_last_of_run);
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    initial begin
        t_drow row;
        int i;
        for (i = 0; i < LINE_DEPTH; i++) begin
            line_mem[i] = '0;
        end
        for (i = 0; i < TABLE_DEPTH; i++) begin
            coef_mem[i] = '0;
        end

        // Directed rows run at factor 1 over a zeroed table, so each output is h[0] times
        // the oldest sample held.
        // Unit gain, then two writes outside the table that must be ignored.
        drows.push_back(drow(OP_COEF,   16'sh0000, 1'b0, 9'd0,   16'sh4000, 1'b0, 16'sh0));
        drows.push_back(drow(OP_COEF,   16'sh0000, 1'b0, 9'd320, 16'sh7FFF, 1'b0, 16'sh0));
        drows.push_back(drow(OP_COEF,   16'sh0000, 1'b0, 9'd511, 16'sh8000, 1'b0, 16'sh0));
        // A record of extremes; nothing comes out until the line is full.
        drows.push_back(drow(OP_SAMPLE, 16'sh7FFF, 1'b1, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh8000, 1'b0, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh0001, 1'b0, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'shFFFF, 1'b0, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh7FFF, 1'b0, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh8000, 1'b0, 9'd0, 16'sh0, 1'b1, 16'sh7FFF));
        // A gain of minus two drives both saturation limits.
        drows.push_back(drow(OP_COEF,   16'sh0000, 1'b0, 9'd0, 16'sh8000, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b1, 16'sh7FFF));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b1, -16'sd2));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b1, 16'sd2));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b1, 16'sh8000));
        // A gain of one half after a new record shows rounding of halves upwards.
        drows.push_back(drow(OP_COEF,   16'sh0000, 1'b0, 9'd0, 16'sh2000, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh0001, 1'b1, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'shFFFF, 1'b0, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh0003, 1'b0, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b0, 16'sh0));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b1, 16'sd1));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b1, 16'sd0));
        drows.push_back(drow(OP_SAMPLE, 16'sh0000, 1'b0, 9'd0, 16'sh0, 1'b1, 16'sd2));

        // Hold reset, then release it for good.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        send_idle_pct = 29;
        recv_idle_pct = 82;
        set_factor(1);
        load_table(1'b1);
        for (i = 0; i < drows.size(); i++) begin
            row = drows[i];
            send_beat(row.it, row.typed, row.want);
            n_directed++;
        end

        // Random part over a random table, through several factors and idling patterns.
        load_table(1'b0);
        run_phase(3,   29, 82, 20, 1'b0);
        run_phase(64,  29, 82, 6,  1'b0);
        run_phase(0,   82, 29, 10, 1'b0);
        run_phase(127, 82, 29, 4,  1'b0);
        run_phase($urandom_range(2, 20), 82, 29, 20, 1'b0);
        run_phase(10,  0,  0,  25, 1'b1);
        run_phase(1,   0,  0,  20, 1'b0);
        run_phase(65,  0,  0,  6,  1'b0);
        drain();

        $display("Covered %0d directed and %0d random input beats over %0d factor settings,",
                 n_directed, n_random, n_settings);
        $display("with one long output hold-off; %0d output beats compared, %0d mismatches.",
                 n_checked, errors);
        if (errors == 0 && pending_outs.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/psi_pkg.sv
design/psi_tap_cell.sv
design/psi_sequencer.sv
design/polyphase_sinc_interpolator_core.sv
tb/tb.sv
